FILE: design/mesh_world_transform_face_normals_macros.svh
// Assertion macros for the world transform and face normal block
`ifndef MESH_WORLD_TRANSFORM_FACE_NORMALS_MACROS_SVH
`define MESH_WORLD_TRANSFORM_FACE_NORMALS_MACROS_SVH
`define MWT_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("implication failed");
`define MWT_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("next-cycle check failed");
`endif

FILE: design/mwtfn_pkg.sv
// Shared types and constants of the world transform and face normal block
`timescale 1ns / 1ps
package mwtfn_pkg;
	localparam int VERTEX_DEPTH_DEF = 1024;
	localparam int FRAC_BITS_DEF = 16;
	localparam int IDX_W = 10;
	localparam int CRD_W = 32;
	localparam logic [1:0] CMD_MAT = 2'd0;
	localparam logic [1:0] CMD_VTX = 2'd1;
	localparam logic [1:0] CMD_FACE = 2'd2;
	localparam logic KIND_VTX = 1'b0;
	localparam logic KIND_NRM = 1'b1;

	typedef struct packed {
		logic load;
		logic mac_clr;
		logic mac_en;
		logic [1:0] row;
		logic [1:0] col;
		logic vtx_done;
		logic rd_en;
		logic [1:0] rd_sel;
		logic rd_cap;
		logic [1:0] cap_sel;
		logic cr_en;
		logic [2:0] cr_step;
		logic norm_start;
		logic div_start;
		logic [1:0] div_sel;
		logic emit_vtx;
		logic emit_nrm;
	} ctl_t;

	typedef struct packed {
		logic mac_done;
		logic zero;
		logic sqrt_done;
		logic div_done;
	} sts_t;
endpackage

FILE: design/mwtfn_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read
`timescale 1ns / 1ps
module mwtfn_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: design/mwtfn_ctrl.sv
// Controller state machine sequencing matrix, vertex and face items
`timescale 1ns / 1ps
module mwtfn_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] command,
	input logic [1:0] mat_row,
	input logic enable,
	input mwtfn_pkg::sts_t sts,
	output mwtfn_pkg::ctl_t ctl,
	output logic busy,
	output logic mat_we
);
	import mwtfn_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MAC = 4'd1;
	localparam logic [3:0] S_VOUT = 4'd2;
	localparam logic [3:0] S_RD = 4'd3;
	localparam logic [3:0] S_CR = 4'd4;
	localparam logic [3:0] S_ZCHK = 4'd5;
	localparam logic [3:0] S_SQRT = 4'd6;
	localparam logic [3:0] S_DIV = 4'd7;
	localparam logic [3:0] S_NOUT = 4'd8;

	logic [3:0] state_q;
	logic [1:0] row_q, col_q, sel_q;
	logic [2:0] stp_q;
	logic dstart_q;
	logic take;

	assign take = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign mat_we = take && (command == CMD_MAT) && (mat_row != 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q <= '0;
			col_q <= '0;
			sel_q <= '0;
			stp_q <= '0;
			dstart_q <= 1'b0;
		end else begin
			dstart_q <= ((state_q == S_SQRT) && sts.sqrt_done) ||
				((state_q == S_DIV) && sts.div_done && !dstart_q && (sel_q != 2'd2));
			unique case (state_q)
				S_IDLE: begin
					row_q <= '0;
					col_q <= '0;
					sel_q <= '0;
					stp_q <= '0;
					if (take && enable && command == CMD_VTX) begin
						state_q <= S_MAC;
					end else if (take && enable && command == CMD_FACE) begin
						state_q <= S_RD;
					end
				end
				S_MAC: begin
					if (col_q == 2'd3) begin
						col_q <= '0;
						if (row_q == 2'd2) begin
							state_q <= S_VOUT;
						end else begin
							row_q <= row_q + 2'd1;
						end
					end else begin
						col_q <= col_q + 2'd1;
					end
				end
				S_VOUT: state_q <= S_IDLE;
				S_RD: begin
					if (sel_q == 2'd3) begin
						state_q <= S_CR;
						sel_q <= '0;
					end else begin
						sel_q <= sel_q + 2'd1;
					end
				end
				S_CR: begin
					if (stp_q == 3'd6) begin
						state_q <= S_ZCHK;
					end
					stp_q <= stp_q + 3'd1;
				end
				S_ZCHK: begin
					if (sts.zero) begin
						state_q <= S_NOUT;
					end else begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sts.sqrt_done) begin
						state_q <= S_DIV;
						sel_q <= '0;
					end
				end
				S_DIV: begin
					if (sts.div_done && !dstart_q) begin
						if (sel_q == 2'd2) begin
							state_q <= S_NOUT;
						end else begin
							sel_q <= sel_q + 2'd1;
						end
					end
				end
				S_NOUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl = '0;
		ctl.load = take;
		ctl.mac_clr = (state_q == S_MAC) && (col_q == 2'd0);
		ctl.mac_en = (state_q == S_MAC);
		ctl.row = row_q;
		ctl.col = col_q;
		ctl.vtx_done = (state_q == S_VOUT);
		ctl.rd_en = (state_q == S_RD) && (sel_q != 2'd3);
		ctl.rd_sel = sel_q;
		ctl.rd_cap = (state_q == S_RD) && (sel_q != 2'd0);
		ctl.cap_sel = sel_q - 2'd1;
		ctl.cr_en = (state_q == S_CR);
		ctl.cr_step = stp_q;
		ctl.norm_start = (state_q == S_ZCHK) && !sts.zero;
		ctl.div_start = dstart_q;
		ctl.div_sel = sel_q;
		ctl.emit_vtx = (state_q == S_VOUT);
		ctl.emit_nrm = (state_q == S_NOUT);
	end
endmodule

FILE: design/mwtfn_dp.sv
// Datapath: matrix, transform accumulator, vertex store, cross, root and divider
`timescale 1ns / 1ps
module mwtfn_dp #(
	parameter int VERTEX_DEPTH = mwtfn_pkg::VERTEX_DEPTH_DEF,
	parameter int FRAC_BITS = mwtfn_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input mwtfn_pkg::ctl_t ctl,
	output mwtfn_pkg::sts_t sts,
	input logic mat_we,
	input logic [1:0] mat_row,
	input logic [1:0] mat_col,
	input logic signed [31:0] mat_value,
	input logic [9:0] vert_index,
	input logic signed [31:0] in_x,
	input logic signed [31:0] in_y,
	input logic signed [31:0] in_z,
	input logic [9:0] face_a,
	input logic [9:0] face_b,
	input logic [9:0] face_c,
	output logic kind,
	output logic [9:0] out_index,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic degenerate,
	output logic saturated,
	output logic out_valid
);
	import mwtfn_pkg::*;

	localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam int ACC_W = 68;

	logic signed [31:0] mat_q [3][4];
	logic [9:0] idx_q, fa_q, fb_q, fc_q;
	logic signed [31:0] vin_q [3];
	logic signed [ACC_W-1:0] acc_q;
	logic signed [31:0] wres_q [3];
	logic sat_q;
	logic signed [63:0] prod;
	logic signed [31:0] clamped;
	logic ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 4; c++) begin
					mat_q[r][c] <= '0;
				end
			end
		end else if (mat_we) begin
			mat_q[mat_row][mat_col] <= mat_value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			idx_q <= vert_index;
			vin_q[0] <= in_x;
			vin_q[1] <= in_y;
			vin_q[2] <= in_z;
			fa_q <= face_a;
			fb_q <= face_b;
			fc_q <= face_c;
		end
	end

	// sum of products is exact; one floor shift of the total equals the split form
	assign prod = mat_q[ctl.row][ctl.col[1:0]] * vin_q[ctl.col];

	always_comb begin
		logic signed [ACC_W-1:0] tot;
		tot = acc_q >>> FRAC_BITS;
		tot = tot + ACC_W'(mat_q[ctl.row][3]);
		ovf = (tot > ACC_W'(64'sd2147483647)) || (tot < -ACC_W'(64'sd2147483648));
		if (tot > ACC_W'(64'sd2147483647)) begin
			clamped = 32'sh7fffffff;
		end else if (tot < -ACC_W'(64'sd2147483648)) begin
			clamped = 32'sh80000000;
		end else begin
			clamped = tot[31:0];
		end
	end

	logic fin_q;
	logic [1:0] frow_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= 1'b0;
			frow_q <= '0;
		end else begin
			fin_q <= ctl.mac_en && (ctl.col == 2'd2);
			frow_q <= ctl.row;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sat_q <= 1'b0;
		end
		if (ctl.mac_en && ctl.col != 2'd3) begin
			acc_q <= (ctl.mac_clr ? '0 : acc_q) + ACC_W'(prod);
		end
		if (fin_q) begin
			wres_q[frow_q] <= clamped;
			if (ovf) begin
				sat_q <= 1'b1;
			end
		end
	end

	logic vfin_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vfin_q <= 1'b0;
		end else begin
			vfin_q <= ctl.vtx_done;
		end
	end

	// vertex store
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [95:0] rdata;
	logic [9:0] ridx;
	logic [9:0] cidx_q;
	logic rvalid_q;

	assign we = ctl.emit_vtx && (32'(idx_q) < VERTEX_DEPTH);
	assign waddr = AW'(idx_q);
	always_comb begin
		unique case (ctl.rd_sel)
			2'd0: ridx = fa_q;
			2'd1: ridx = fb_q;
			default: ridx = fc_q;
		endcase
	end
	assign raddr = AW'(ridx);

	mwtfn_ram #(.WIDTH(96), .DEPTH(VERTEX_DEPTH)) u_store (
		.clk(clk), .we(we), .waddr(waddr),
		.wdata({wres_q[2], wres_q[1], wres_q[0]}),
		.re(ctl.rd_en), .raddr(raddr), .rdata(rdata)
	);

	logic signed [31:0] vtx_q [3][3];
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rvalid_q <= (32'(ridx) < VERTEX_DEPTH);
		end
		if (ctl.rd_cap) begin
			for (int k = 0; k < 3; k++) begin
				vtx_q[ctl.cap_sel][k] <= rvalid_q ? rdata[32*k +: 32] : '0;
			end
		end
	end

	// cross product over steps: 0 edges, 1..6 products, accumulated per component
	logic signed [32:0] e1_q [3], e2_q [3];
	logic signed [66:0] cr_q [3];
	logic signed [32:0] ma, mb;
	logic signed [65:0] mp;
	logic [1:0] ci;
	logic sub;

	always_comb begin
		ma = '0;
		mb = '0;
		ci = 2'd0;
		sub = 1'b0;
		unique case (ctl.cr_step)
			3'd1: begin ma = e1_q[1]; mb = e2_q[2]; ci = 2'd0; end
			3'd2: begin ma = e1_q[2]; mb = e2_q[1]; ci = 2'd0; sub = 1'b1; end
			3'd3: begin ma = e1_q[2]; mb = e2_q[0]; ci = 2'd1; end
			3'd4: begin ma = e1_q[0]; mb = e2_q[2]; ci = 2'd1; sub = 1'b1; end
			3'd5: begin ma = e1_q[0]; mb = e2_q[1]; ci = 2'd2; end
			3'd6: begin ma = e1_q[1]; mb = e2_q[0]; ci = 2'd2; sub = 1'b1; end
			default: begin ma = '0; mb = '0; end
		endcase
	end
	assign mp = ma * mb;

	always_ff @(posedge clk) begin
		if (ctl.cr_en) begin
			if (ctl.cr_step == 3'd0) begin
				for (int k = 0; k < 3; k++) begin
					e1_q[k] <= 33'(vtx_q[1][k]) - 33'(vtx_q[0][k]);
					e2_q[k] <= 33'(vtx_q[2][k]) - 33'(vtx_q[0][k]);
					cr_q[k] <= '0;
				end
			end else if (sub) begin
				cr_q[ci] <= cr_q[ci] - 67'(mp);
			end else begin
				cr_q[ci] <= cr_q[ci] + 67'(mp);
			end
		end
	end

	logic [65:0] mag [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mag[k] = cr_q[k][66] ? 66'(-cr_q[k]) : cr_q[k][65:0];
		end
	end
	assign sts.zero = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);

	// scale by bit length, then shift-subtract root until the root bit has shifted out
	logic [65:0] orm;
	logic [6:0] bl;
	always_comb begin
		orm = mag[0] | mag[1] | mag[2];
		bl = '0;
		for (int i = 0; i < 66; i++) begin
			if (orm[i]) begin
				bl = 7'(i + 1);
			end
		end
	end

	logic [29:0] d_q [3];
	logic [61:0] rem_q;
	logic [63:0] len2;
	logic [63:0] root_q;
	logic [63:0] rbit_q;
	logic sq_run_q, sq_ld_q;
	logic [61:0] sq_in_q;
	logic [1:0] sq_k_q;

	always_comb begin
		len2 = '0;
		for (int k = 0; k < 3; k++) begin
			len2 = len2 + 64'(d_q[k]) * 64'(d_q[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_run_q <= 1'b0;
			sq_ld_q <= 1'b0;
		end else begin
			sq_ld_q <= ctl.norm_start;
			if (sq_ld_q) begin
				sq_run_q <= 1'b1;
			end else if (sq_run_q && rbit_q == '0) begin
				sq_run_q <= 1'b0;
			end
		end
	end

	logic [63:0] rsum;
	assign rsum = root_q + rbit_q;
	logic [63:0] rem64;
	assign rem64 = {2'b00, rem_q};

	always_ff @(posedge clk) begin
		if (ctl.norm_start) begin
			for (int k = 0; k < 3; k++) begin
				if (bl > 7'd30) begin
					d_q[k] <= 30'(mag[k] >> (bl - 7'd30));
				end else begin
					d_q[k] <= 30'(mag[k] << (7'd30 - bl));
				end
			end
		end
		if (sq_ld_q) begin
			rem_q <= 62'(len2);
			root_q <= '0;
			rbit_q <= 64'h1000_0000_0000_0000;
		end else if (sq_run_q && rbit_q != '0) begin
			if (rem64 >= rsum) begin
				rem_q <= 62'(rem64 - rsum);
				root_q <= (root_q >> 1) + rbit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			rbit_q <= rbit_q >> 2;
		end
	end
	assign sts.sqrt_done = sq_run_q && (rbit_q == '0);

	// restoring divider, one quotient bit per cycle
	localparam int NUM_W = 30 + FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W + 1);
	logic [NUM_W-1:0] num_q;
	logic [31:0] drem_q;
	logic [CNT_W-1:0] dcnt_q;
	logic drun_q;
	logic [1:0] dsel_q;
	logic signed [31:0] nrm_q [3];
	logic neg_sel;
	logic [32:0] trial;

	assign trial = {drem_q, num_q[NUM_W-1]};
	always_comb begin
		neg_sel = cr_q[dsel_q][66];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drun_q <= 1'b0;
			dcnt_q <= '0;
		end else if (ctl.div_start) begin
			drun_q <= 1'b1;
			dcnt_q <= CNT_W'(NUM_W);
		end else if (drun_q) begin
			dcnt_q <= dcnt_q - 1'b1;
			if (dcnt_q == CNT_W'(1)) begin
				drun_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			num_q <= NUM_W'(d_q[ctl.div_sel]) << FRAC_BITS;
			drem_q <= '0;
			dsel_q <= ctl.div_sel;
		end else if (drun_q) begin
			if (trial >= 33'(root_q)) begin
				drem_q <= 32'(trial - 33'(root_q));
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				drem_q <= trial[31:0];
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
			if (dcnt_q == CNT_W'(1)) begin
				nrm_q[dsel_q] <= neg_sel
					? -32'(trial >= 33'(root_q) ? {num_q[NUM_W-2:0], 1'b1}
						: {num_q[NUM_W-2:0], 1'b0})
					: 32'(trial >= 33'(root_q) ? {num_q[NUM_W-2:0], 1'b1}
						: {num_q[NUM_W-2:0], 1'b0});
			end
		end
	end
	assign sts.div_done = !drun_q;
	assign sts.mac_done = vfin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= ctl.emit_vtx || ctl.emit_nrm;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_vtx) begin
			kind <= KIND_VTX;
			out_index <= idx_q;
			out_x <= wres_q[0];
			out_y <= wres_q[1];
			out_z <= wres_q[2];
			degenerate <= 1'b0;
			saturated <= sat_q;
		end else if (ctl.emit_nrm) begin
			kind <= KIND_NRM;
			out_index <= '0;
			degenerate <= sts.zero;
			saturated <= 1'b0;
			if (sts.zero) begin
				out_x <= '0;
				out_y <= 32'sd1 <<< FRAC_BITS;
				out_z <= '0;
			end else begin
				out_x <= nrm_q[0];
				out_y <= nrm_q[1];
				out_z <= nrm_q[2];
			end
		end
	end
endmodule

FILE: design/mesh_world_transform_face_normals.sv
// Top level of the world transform and face normal block
// channel  | signals                                          | handshake
// cfg      | cfg_we, cfg_wdata                                | written when cfg_we
// in       | command, mat_*, vert_index, in_*, face_*         | start && !busy
// out      | kind, out_index, out_*, degenerate, saturated    | strobe, one cycle
// A matrix write does not raise busy; a vertex holds busy on one multiplier reused for each product.
// A face holds busy through the store reads of corners a, b and c, 7 cross steps, a zero check,
// a square root and three divisions on one divider; a degenerate face skips root and divisions.
// The result strobes in the same cycle that busy drops.
// Reset clears matrix, enable (to 1) and control; the vertex store is not cleared.
// The receiver cannot stall; busy holds off new items.
`timescale 1ns / 1ps
`include "mesh_world_transform_face_normals_macros.svh"
module mesh_world_transform_face_normals #(
	parameter int VERTEX_DEPTH = mwtfn_pkg::VERTEX_DEPTH_DEF,
	parameter int FRAC_BITS = mwtfn_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_wdata,
	input logic start,
	output logic busy,
	input logic [1:0] command,
	input logic [1:0] mat_row,
	input logic [1:0] mat_col,
	input logic signed [31:0] mat_value,
	input logic [9:0] vert_index,
	input logic signed [31:0] in_x,
	input logic signed [31:0] in_y,
	input logic signed [31:0] in_z,
	input logic [9:0] face_a,
	input logic [9:0] face_b,
	input logic [9:0] face_c,
	output logic strobe,
	output logic kind,
	output logic [9:0] out_index,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic degenerate,
	output logic saturated
);
	import mwtfn_pkg::*;

	logic enable_q;
	ctl_t ctl;
	sts_t sts;
	logic mat_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_we) begin
			enable_q <= cfg_wdata;
		end
	end

	mwtfn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .command(command),
		.mat_row(mat_row), .enable(enable_q), .sts(sts), .ctl(ctl),
		.busy(busy), .mat_we(mat_we)
	);

	mwtfn_dp #(.VERTEX_DEPTH(VERTEX_DEPTH), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts), .mat_we(mat_we),
		.mat_row(mat_row), .mat_col(mat_col), .mat_value(mat_value),
		.vert_index(vert_index), .in_x(in_x), .in_y(in_y), .in_z(in_z),
		.face_a(face_a), .face_b(face_b), .face_c(face_c),
		.kind(kind), .out_index(out_index), .out_x(out_x), .out_y(out_y),
		.out_z(out_z), .degenerate(degenerate), .saturated(saturated),
		.out_valid(strobe)
	);

	`MWT_ASSERT_NXT(a_strobe_single, clk, arst_n, strobe, !strobe)
	`MWT_ASSERT_IMP(a_vtx_clean, clk, arst_n, strobe && kind == KIND_VTX, !degenerate)
	`MWT_ASSERT_IMP(a_nrm_clean, clk, arst_n, strobe && kind == KIND_NRM, !saturated)
endmodule

FILE: tb/mesh_world_transform_face_normals_tb.sv
// Self-checking testbench for the world transform and face normal block
`timescale 1ns / 1ps
module mesh_world_transform_face_normals_tb;
	import mwtfn_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam logic [1:0] ROW_NONE = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 200;
	localparam logic signed [67:0] CRD_MAX = 68'sd2147483647;
	localparam logic signed [67:0] CRD_MIN = -68'sd2147483648;

	typedef struct {
		logic [1:0] cmd;
		logic [1:0] row;
		logic [1:0] col;
		logic signed [31:0] mval;
		logic [9:0] vidx;
		logic signed [31:0] x, y, z;
		logic [9:0] fa, fb, fc;
	} item_t;

	typedef struct {
		logic knd;
		logic [9:0] idx;
		logic signed [31:0] x, y, z;
		logic degen;
		logic sat;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] command = '0;
	logic [1:0] mat_row = '0;
	logic [1:0] mat_col = '0;
	logic signed [31:0] mat_value = '0;
	logic [9:0] vert_index = '0;
	logic signed [31:0] in_x = '0;
	logic signed [31:0] in_y = '0;
	logic signed [31:0] in_z = '0;
	logic [9:0] face_a = '0;
	logic [9:0] face_b = '0;
	logic [9:0] face_c = '0;
	logic strobe;
	logic kind;
	logic [9:0] out_index;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic degenerate;
	logic saturated;

	item_t stim_q[$];
	item_t cur_item;
	result_t expected_q[$];
	logic signed [31:0] world_m[3][4];
	logic signed [31:0] vstore[1024][3];
	logic xform_en = 1'b1;
	logic gen_en = 1'b1;
	bit gen_written[1024];
	int written_list[$];
	bit taken = 1'b0;
	int accepted = 0;
	int stall_cnt = 0;
	int errors = 0;

	always #10 clk = ~clk;

	mesh_world_transform_face_normals u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .command(command), .mat_row(mat_row),
		.mat_col(mat_col), .mat_value(mat_value), .vert_index(vert_index),
		.in_x(in_x), .in_y(in_y), .in_z(in_z), .face_a(face_a), .face_b(face_b),
		.face_c(face_c), .strobe(strobe), .kind(kind), .out_index(out_index),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .degenerate(degenerate),
		.saturated(saturated)
	);

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = '0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [67:0] cross_part(logic signed [67:0] a,
			logic signed [67:0] b, logic signed [67:0] c, logic signed [67:0] d);
		return a * b - c * d;
	endfunction

	task automatic transform_vertex(input item_t it);
		result_t r;
		logic signed [67:0] acc;
		logic signed [67:0] crd[3];
		logic signed [67:0] v[3];
		v[0] = it.x;
		v[1] = it.y;
		v[2] = it.z;
		r.knd = KIND_VTX;
		r.idx = it.vidx;
		r.degen = 1'b0;
		r.sat = 1'b0;
		for (int k = 0; k < 3; k++) begin
			acc = '0;
			for (int c = 0; c < 3; c++)
				acc = acc + 68'(world_m[k][c]) * v[c];
			acc = (acc >>> 16) + 68'(world_m[k][3]);
			if (acc > CRD_MAX) begin
				acc = CRD_MAX;
				r.sat = 1'b1;
			end else if (acc < CRD_MIN) begin
				acc = CRD_MIN;
				r.sat = 1'b1;
			end
			crd[k] = acc;
		end
		r.x = crd[0][31:0];
		r.y = crd[1][31:0];
		r.z = crd[2][31:0];
		for (int k = 0; k < 3; k++)
			vstore[it.vidx][k] = crd[k][31:0];
		expected_q.push_back(r);
	endtask

	task automatic face_normal(input item_t it);
		result_t r;
		logic signed [67:0] e1[3], e2[3], w[3], mag[3];
		logic [63:0] d[3];
		logic [63:0] len2, root, q;
		int bl;
		for (int k = 0; k < 3; k++) begin
			e1[k] = 68'(vstore[it.fb][k]) - 68'(vstore[it.fa][k]);
			e2[k] = 68'(vstore[it.fc][k]) - 68'(vstore[it.fa][k]);
		end
		w[0] = cross_part(e1[1], e2[2], e1[2], e2[1]);
		w[1] = cross_part(e1[2], e2[0], e1[0], e2[2]);
		w[2] = cross_part(e1[0], e2[1], e1[1], e2[0]);
		bl = 0;
		for (int k = 0; k < 3; k++) begin
			mag[k] = w[k] < 0 ? -w[k] : w[k];
			for (int b = 0; b < 68; b++)
				if (mag[k][b] && b + 1 > bl)
					bl = b + 1;
		end
		r.knd = KIND_NRM;
		r.idx = '0;
		r.sat = 1'b0;
		if (bl == 0) begin
			r.degen = 1'b1;
			r.x = '0;
			r.y = 32'sd1 << 16;
			r.z = '0;
		end else begin
			r.degen = 1'b0;
			len2 = '0;
			for (int k = 0; k < 3; k++) begin
				d[k] = bl > 30 ? 64'(mag[k] >> (bl - 30)) : 64'(mag[k] << (30 - bl));
				len2 = len2 + d[k] * d[k];
			end
			root = int_sqrt(len2);
			for (int k = 0; k < 3; k++) begin
				q = (d[k] << 16) / root;
				if (w[k] < 0)
					q = -q;
				case (k)
					0: r.x = q[31:0];
					1: r.y = q[31:0];
					default: r.z = q[31:0];
				endcase
			end
		end
		expected_q.push_back(r);
	endtask

	task automatic apply_item(input item_t it);
		if (it.cmd == CMD_MAT) begin
			if (it.row != ROW_NONE)
				world_m[it.row][it.col] = it.mval;
		end else if (xform_en && it.cmd == CMD_VTX) begin
			transform_vertex(it);
		end else if (xform_en && it.cmd == CMD_FACE) begin
			face_normal(it);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] e,
			input logic [31:0] a);
		if (e !== a) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t e;
		taken = 1'b0;
		if (arst_n) begin
			if (cfg_we)
				xform_en = cfg_wdata;
			if (start && !busy) begin
				apply_item(cur_item);
				taken = 1'b1;
				accepted++;
			end
			if (strobe) begin
				if (expected_q.size() == 0) begin
					$display("%0t unexpected result: kind %0d index %0d", $time, kind, out_index);
					errors++;
				end else begin
					e = expected_q.pop_front();
					check_field("kind", e.knd, kind);
					check_field("out_index", e.idx, out_index);
					check_field("out_x", e.x, out_x);
					check_field("out_y", e.y, out_y);
					check_field("out_z", e.z, out_z);
					check_field("degenerate", e.degen, degenerate);
					check_field("saturated", e.sat, saturated);
				end
			end
			stall_cnt = (taken || strobe) ? 0 : stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		bit quiet;
		quiet = accepted >= 300 && accepted < 450;
		if (arst_n && (!start || taken)) begin
			if (stim_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 7)) begin
				cur_item = stim_q.pop_front();
				command <= cur_item.cmd;
				mat_row <= cur_item.row;
				mat_col <= cur_item.col;
				mat_value <= cur_item.mval;
				vert_index <= cur_item.vidx;
				in_x <= cur_item.x;
				in_y <= cur_item.y;
				in_z <= cur_item.z;
				face_a <= cur_item.fa;
				face_b <= cur_item.fb;
				face_c <= cur_item.fc;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	function automatic logic [31:0] rand_crd();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
			default: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		endcase
	endfunction

	function automatic item_t blank_item(input logic [1:0] cmd);
		item_t it;
		it.cmd = cmd;
		it.row = 2'($urandom_range(0, 3));
		it.col = 2'($urandom_range(0, 3));
		it.mval = $urandom();
		it.vidx = 10'($urandom_range(0, 1023));
		it.x = $urandom();
		it.y = $urandom();
		it.z = $urandom();
		it.fa = '0;
		it.fb = '0;
		it.fc = '0;
		return it;
	endfunction

	task automatic push_mat(input logic [1:0] row, input logic [1:0] col,
			input logic [31:0] value);
		item_t it;
		it = blank_item(CMD_MAT);
		it.row = row;
		it.col = col;
		it.mval = value;
		stim_q.push_back(it);
	endtask

	task automatic push_vtx(input logic [9:0] idx, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z);
		item_t it;
		it = blank_item(CMD_VTX);
		it.vidx = idx;
		it.x = x;
		it.y = y;
		it.z = z;
		if (gen_en && !gen_written[idx]) begin
			gen_written[idx] = 1'b1;
			written_list.push_back(idx);
		end
		stim_q.push_back(it);
	endtask

	task automatic push_face(input logic [9:0] a, input logic [9:0] b,
			input logic [9:0] c);
		item_t it;
		it = blank_item(CMD_FACE);
		it.fa = a;
		it.fb = b;
		it.fc = c;
		stim_q.push_back(it);
	endtask

	function automatic logic [9:0] pick_written();
		return 10'(written_list[$urandom_range(0, written_list.size() - 1)]);
	endfunction

	task automatic push_random(input int n);
		logic [9:0] a;
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 15) begin
				push_mat(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
					$urandom_range(0, 7) == 0 ? $urandom()
					: $signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000);
			end else if (sel < 55) begin
				push_vtx(10'($urandom_range(0, 1023)), rand_crd(), rand_crd(), rand_crd());
			end else if (sel < 97) begin
				a = pick_written();
				case ($urandom_range(0, 9))
					0: push_face(a, a, pick_written());
					1: push_face(a, pick_written(), a);
					default: push_face(a, pick_written(), pick_written());
				endcase
			end else begin
				stim_q.push_back(blank_item(CMD_NONE));
			end
		end
	endtask

	task automatic drain_and_config(input logic en);
		while (stim_q.size() != 0 || start || expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= en;
		@(negedge clk);
		cfg_we <= 1'b0;
		gen_en = en;
	endtask

	initial begin
		@(negedge clk);
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		drain_and_config(1'b1);

		push_mat(0, 0, 32'h0001_0000);
		push_mat(1, 1, 32'h0001_0000);
		push_mat(2, 2, 32'h0001_0000);
		push_mat(0, 3, 32'h0000_0001);
		push_mat(1, 3, 32'hFFFF_FFFF);
		push_mat(ROW_NONE, 1, 32'h7FFF_FFFF);
		push_vtx(0, 0, 0, 0);
		push_vtx(1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_vtx(512, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		push_mat(0, 3, 0);
		push_mat(1, 3, 0);
		push_vtx(1, 32'h0001_0000, 0, 0);
		push_vtx(2, 0, 32'h0001_0000, 0);
		push_vtx(3, 32'h0002_0000, 0, 0);
		push_face(0, 1, 2);
		push_face(0, 0, 0);
		push_face(0, 1, 3);
		push_face(512, 1023, 1);
		push_vtx(4, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		push_vtx(5, 32'h8000_0000, 0, 32'h7FFF_FFFF);
		push_face(4, 5, 512);
		stim_q.push_back(blank_item(CMD_NONE));
		push_mat(2, 0, 32'h8000_0000);
		push_vtx(6, 32'h7FFF_FFFF, 32'h0000_1234, 32'hFFFF_0000);
		push_mat(2, 0, 0);
		push_random(400);

		drain_and_config(1'b0);
		push_random(40);

		drain_and_config(1'b1);
		push_random(400);

		while (stim_q.size() != 0 || start || expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+design
design/mwtfn_pkg.sv
design/mwtfn_ram.sv
design/mwtfn_ctrl.sv
design/mwtfn_dp.sv
design/mesh_world_transform_face_normals.sv
tb/mesh_world_transform_face_normals_tb.sv
